// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRIO_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;   // width of the reported entry count

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the incoming item
        logic check;    // evaluate the compare row and the reject condition
        logic finish;   // write the result registers
        logic commit;   // shift the entry array and update the count
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reject;   // insert into full queue or remove from empty queue
    } t_sts;

endpackage

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a sorted compare-and-shift register array.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_action, i_priority_req, i_value with start high;
//   the command transfers at a rising edge where start is high and busy is
//   low. Insert (action 0) places the entry behind every entry of greater or
//   equal priority; remove (action 1) pops the head entry's value.
//   Result channel: o_valid is high for exactly one cycle with
//   o_removed_value, o_status and o_entry_count. The receiver cannot stall,
//   so the result must be taken in that cycle.
//   Sequence: the compare state registers the compare row over all DEPTH
//   entries, the update state shifts the array and writes the result
//   registers, and the strobe follows in the cycle after it. A new command
//   may transfer in the update state; busy is high only in the compare state.
//   Full insert / empty remove return status FULL / EMPTY with zero value
//   and leave the queue unchanged.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any command
//   in flight; entry contents are not cleared, the count masks them.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_action,
    input  logic        [spq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_removed_value,
    output logic        [spq_pkg::STATUS_W-1:0] o_status,
    output logic        [spq_pkg::COUNT_W-1:0]  o_entry_count
);
    import spq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // entry array, compare row and result registers
    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_priority_req  (i_priority_req),
        .i_value         (i_value),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

endmodule

// ----- hdl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: capture, compare, update. Drives busy and the result strobe.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output spq_pkg::t_cmd o_cmd,
    input  spq_pkg::t_sts i_sts
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        busy         = 1'b0;
        n_valid      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                busy        = 1'b1;
                o_cmd.check = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                // next item may be captured while this one retires
                o_cmd.finish = 1'b1;
                o_cmd.commit = !i_sts.reject;
                n_valid      = 1'b1;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;

    a_cmp_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |=> r_state == S_UPD)
        else $error("compare not followed by update");

    a_valid_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |=> r_valid)
        else $error("missing result strobe");

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cmd.load)
        else $error("capture while busy");

endmodule

// ----- hdl/spq_dp.sv -----
// ----------------------------------------------------------------------------
// spq_dp
// Compare-and-shift entry array with input and result registers.
// ----------------------------------------------------------------------------
module spq_dp #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_cmd                       i_cmd,
    output spq_pkg::t_sts                       o_sts,
    input  logic                                i_action,
    input  logic        [spq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_value,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_removed_value,
    output logic        [spq_pkg::STATUS_W-1:0] o_status,
    output logic        [spq_pkg::COUNT_W-1:0]  o_entry_count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic               r_op;
    logic [PRIO_W-1:0]  r_prio;
    logic [VALUE_W-1:0] r_val;

    logic [PRIO_W-1:0]  r_ent_prio [DEPTH];
    logic [VALUE_W-1:0] r_ent_val  [DEPTH];
    logic [CNT_W-1:0]   r_count;

    logic [DEPTH-1:0]   r_ge;       // entry i valid and priority >= new one
    logic               r_reject;

    logic [VALUE_W-1:0]  r_removed;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_action;
            r_prio <= i_priority_req;
            r_val  <= i_value;
        end
    end

    // compare row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cmp
        always_ff @(posedge i_clk) begin
            if (i_cmd.check) begin
                r_ge[gi] <= (CNT_W'(gi) < r_count) && (r_ent_prio[gi] >= r_prio);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_reject <= (r_op == ACT_INSERT) ? (r_count == CNT_W'(DEPTH))
                                             : (r_count == '0);
        end
    end

    assign o_sts.reject = r_reject;

    // entry cells: insert opens a gap at the first empty or lower-priority slot,
    // remove shifts everything one toward the head
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.commit) begin
                if (r_op == ACT_INSERT) begin
                    if (!r_ge[gi]) begin
                        if (gi == 0) begin
                            r_ent_prio[gi] <= r_prio;
                            r_ent_val[gi]  <= r_val;
                        end else if (r_ge[(gi == 0) ? 0 : gi - 1]) begin
                            r_ent_prio[gi] <= r_prio;
                            r_ent_val[gi]  <= r_val;
                        end else begin
                            r_ent_prio[gi] <= r_ent_prio[(gi == 0) ? 0 : gi - 1];
                            r_ent_val[gi]  <= r_ent_val[(gi == 0) ? 0 : gi - 1];
                        end
                    end
                end else if (gi < DEPTH - 1) begin
                    r_ent_prio[gi] <= r_ent_prio[(gi < DEPTH - 1) ? gi + 1 : gi];
                    r_ent_val[gi]  <= r_ent_val[(gi < DEPTH - 1) ? gi + 1 : gi];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == ACT_INSERT) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_reject) begin
                r_removed <= '0;
                r_status  <= (r_op == ACT_REMOVE) ? ST_EMPTY : ST_FULL;
            end else begin
                r_removed <= (r_op == ACT_REMOVE) ? r_ent_val[0] : '0;
                r_status  <= ST_OK;
            end
        end
    end

    assign count_ext       = (CNT_W + COUNT_W)'(r_count);
    assign o_entry_count   = count_ext[COUNT_W-1:0];
    assign o_removed_value = r_removed;
    assign o_status        = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == ACT_INSERT) |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the count");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == ACT_REMOVE) |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not shrink the count");

endmodule
